// ----- rtl/ssrg_pkg.sv -----
// Shared types, constants and the glyph segment table of the seven-segment rectangle generator.
`timescale 1ns / 1ps

package ssrg_pkg;

  // Default for the coordinate wrap width.
  localparam int unsigned COORD_WIDTH_DEFAULT = 16;

  // Stream payload widths, padded to whole bytes.
  localparam int unsigned S_TDATA_W = 72;
  localparam int unsigned M_TDATA_W = 80;

  // Configuration register indexes and reset values.
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_STROKE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd2;

  localparam logic [15:0] STROKE_RESET = 16'd4;
  localparam logic [15:0] WIDTH_RESET  = 16'd24;
  localparam logic [15:0] HEIGHT_RESET = 16'd40;

  // Glyph codes at or above this count are rejected for digit cells.
  localparam logic [3:0] GLYPH_COUNT = 4'd12;

  // Depth of the queue between the front and the back end.
  localparam int unsigned QUEUE_DEPTH = 4;

  // Segment bits, segment a in bit 0 through segment g in bit 6.
  localparam logic [6:0] SEG_A = 7'h01;
  localparam logic [6:0] SEG_B = 7'h02;
  localparam logic [6:0] SEG_C = 7'h04;
  localparam logic [6:0] SEG_D = 7'h08;
  localparam logic [6:0] SEG_E = 7'h10;
  localparam logic [6:0] SEG_F = 7'h20;
  localparam logic [6:0] SEG_G = 7'h40;

  typedef enum logic [1:0] {
    OP_DIGIT,
    OP_COLON,
    OP_ERROR
  } op_e;

  // One drawing request as it arrives on the input stream.
  typedef struct packed {
    logic        kind;
    logic [15:0] x;
    logic [15:0] y;
    logic [3:0]  glyph;
    logic [15:0] lit_color;
    logic [15:0] dark_color;
  } req_t;

  // Cell geometry derived from the style registers.
  typedef struct packed {
    logic [15:0] stroke;
    logic [15:0] bar;
    logic [15:0] arm;
    logic [15:0] x_right;
    logic [15:0] y_low;
    logic [15:0] y_mid;
    logic [15:0] y_bot;
  } style_t;

  // A classified request waiting for the back end.
  typedef struct packed {
    op_e         op;
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] y_alt;
    logic [6:0]  lit;
    logic [15:0] lit_color;
    logic [15:0] dark_color;
  } entry_t;

  // One rectangle result.
  typedef struct packed {
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] w;
    logic [15:0] h;
    logic [15:0] color;
    logic        status;
    logic        last;
  } result_t;

  function automatic logic [6:0] glyph_segments(input logic [3:0] code);
    logic [6:0] seg;
    case (code)
      4'd0:    seg = SEG_A | SEG_B | SEG_C | SEG_D | SEG_E | SEG_F;
      4'd1:    seg = SEG_B | SEG_C;
      4'd2:    seg = SEG_A | SEG_B | SEG_G | SEG_E | SEG_D;
      4'd3:    seg = SEG_A | SEG_B | SEG_G | SEG_C | SEG_D;
      4'd4:    seg = SEG_F | SEG_G | SEG_B | SEG_C;
      4'd5:    seg = SEG_A | SEG_F | SEG_G | SEG_C | SEG_D;
      4'd6:    seg = SEG_A | SEG_F | SEG_G | SEG_E | SEG_C | SEG_D;
      4'd7:    seg = SEG_A | SEG_B | SEG_C;
      4'd8:    seg = SEG_A | SEG_B | SEG_C | SEG_D | SEG_E | SEG_F | SEG_G;
      4'd9:    seg = SEG_A | SEG_B | SEG_C | SEG_D | SEG_F | SEG_G;
      4'd11:   seg = SEG_G;
      default: seg = '0;
    endcase
    return seg;
  endfunction

endpackage

// ----- rtl/ssrg_front.sv -----
// Front end: style registers, derived geometry, input register and request classification.
`timescale 1ns / 1ps

module ssrg_front (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [ssrg_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [15:0]                       cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  ssrg_pkg::req_t                    req_i,
  output logic                              push_o,
  output ssrg_pkg::entry_t                  entry_o,
  input  logic                              full_i,
  output ssrg_pkg::style_t                  style_o
);
  import ssrg_pkg::*;

  logic [15:0] stroke_q, width_q, height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stroke_q <= STROKE_RESET;
      width_q  <= WIDTH_RESET;
      height_q <= HEIGHT_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_STROKE: stroke_q <= cfg_data_i;
        CFG_WIDTH:  width_q  <= cfg_data_i;
        CFG_HEIGHT: height_q <= cfg_data_i;
        default:    ;
      endcase
    end
  end

  // Style checks run at full precision.
  logic [16:0] two_s;
  logic [17:0] three_s;
  logic [17:0] arm_diff;
  logic [15:0] mid_diff;
  logic [16:0] low_sum;
  logic        ok_d, ok_q;
  style_t      style_d, style_q;
  logic [31:0] prod1_d, prod1_q;
  logic [33:0] prod2_d, prod2_q;

  always_comb begin
    two_s    = {stroke_q, 1'b0};
    three_s  = {1'b0, two_s} + {2'b00, stroke_q};
    ok_d     = (stroke_q != '0) && ({1'b0, width_q} > two_s) &&
               ({2'b00, height_q} >= (three_s + 18'd2)) && (height_q[0] == stroke_q[0]);
    arm_diff = {2'b00, height_q} - three_s;
    mid_diff = height_q - stroke_q;
    low_sum  = {1'b0, height_q} + {1'b0, stroke_q};
    // With the style valid, s + arm = (h - s) / 2 and 2s + arm = (h + s) / 2.
    style_d.stroke  = stroke_q;
    style_d.bar     = width_q - two_s[15:0];
    style_d.arm     = arm_diff[16:1];
    style_d.x_right = width_q - stroke_q;
    style_d.y_low   = low_sum[16:1];
    style_d.y_mid   = {1'b0, mid_diff[15:1]};
    style_d.y_bot   = height_q - stroke_q;
    // Thirds of the height by reciprocal multiplication, exact over the whole range.
    prod1_d = {16'b0, height_q} * 32'h0000AAAB;
    prod2_d = {17'b0, height_q, 1'b0} * 34'h15556;
  end

  always_ff @(posedge clk_i) begin
    ok_q    <= ok_d;
    style_q <= style_d;
    prod1_q <= prod1_d;
    prod2_q <= prod2_d;
  end

  assign style_o = style_q;

  // Input register.
  logic in_v_q, in_v_d;
  req_t req_q;

  assign push_o     = in_v_q && !full_i;
  assign in_ready_o = !in_v_q || !full_i;

  always_comb begin
    in_v_d = in_v_q;
    if (in_valid_i && in_ready_o) begin
      in_v_d = 1'b1;
    end else if (push_o) begin
      in_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else begin
      in_v_q <= in_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      req_q <= req_i;
    end
  end

  // Classification.
  logic [15:0] half_s;
  logic [15:0] colon_y1, colon_y2;
  logic        bad;

  always_comb begin
    half_s   = {1'b0, style_q.stroke[15:1]};
    colon_y1 = req_q.y + {1'b0, prod1_q[31:17]} - half_s;
    colon_y2 = req_q.y + prod2_q[33:18] - half_s;
    bad      = !ok_q || (!req_q.kind && (req_q.glyph >= GLYPH_COUNT));

    entry_o.x          = req_q.x;
    entry_o.y          = req_q.y;
    entry_o.y_alt      = colon_y2;
    entry_o.lit        = glyph_segments(req_q.glyph);
    entry_o.lit_color  = req_q.lit_color;
    entry_o.dark_color = req_q.dark_color;
    if (bad) begin
      entry_o.op = OP_ERROR;
    end else if (req_q.kind) begin
      entry_o.op = OP_COLON;
      entry_o.y  = colon_y1;
    end else begin
      entry_o.op = OP_DIGIT;
    end
  end

endmodule

// ----- rtl/ssrg_queue.sv -----
// Short queue of classified requests between the front and the back end.
`timescale 1ns / 1ps

module ssrg_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  ssrg_pkg::entry_t entry_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output ssrg_pkg::entry_t head_o
);
  import ssrg_pkg::*;

  localparam int unsigned PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(QUEUE_DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(QUEUE_DEPTH);

  entry_t          mem_q [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;

  assign full_o  = (count_q == FullCnt);
  assign valid_o = (count_q != '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

// ----- rtl/ssrg_back.sv -----
// Back end: steps through the rectangles of one request and holds them in the output register.
`timescale 1ns / 1ps

module ssrg_back #(
  parameter int unsigned COORD_WIDTH = ssrg_pkg::COORD_WIDTH_DEFAULT
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              head_valid_i,
  input  ssrg_pkg::entry_t  head_i,
  output logic              pop_o,
  input  ssrg_pkg::style_t  style_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output ssrg_pkg::result_t out_o
);
  import ssrg_pkg::*;

  localparam logic [15:0] CoordMask = 16'((32'd1 << COORD_WIDTH) - 32'd1);
  localparam logic [2:0]  ColonLastStep = 3'd1;
  localparam logic [2:0]  DigitLastStep = 3'd6;

  logic       cur_v_q;
  entry_t     cur_q;
  logic [2:0] step_q;
  logic       out_v_q;
  result_t    out_q;
  result_t    rect;
  logic       load;
  logic [15:0] x_off, y_off;

  always_comb begin
    x_off  = '0;
    y_off  = '0;
    rect   = '0;
    case (cur_q.op)
      OP_COLON: begin
        rect.x     = cur_q.x;
        rect.y     = (step_q == '0) ? cur_q.y : cur_q.y_alt;
        rect.w     = style_i.stroke;
        rect.h     = style_i.stroke;
        rect.color = cur_q.lit_color;
        rect.last  = (step_q == ColonLastStep);
      end
      OP_DIGIT: begin
        // Segments a to g in order.
        case (step_q)
          3'd0: begin
            x_off = style_i.stroke;  y_off = '0;
            rect.w = style_i.bar;    rect.h = style_i.stroke;
          end
          3'd1: begin
            x_off = style_i.x_right; y_off = style_i.stroke;
            rect.w = style_i.stroke; rect.h = style_i.arm;
          end
          3'd2: begin
            x_off = style_i.x_right; y_off = style_i.y_low;
            rect.w = style_i.stroke; rect.h = style_i.arm;
          end
          3'd3: begin
            x_off = style_i.stroke;  y_off = style_i.y_bot;
            rect.w = style_i.bar;    rect.h = style_i.stroke;
          end
          3'd4: begin
            x_off = '0;              y_off = style_i.y_low;
            rect.w = style_i.stroke; rect.h = style_i.arm;
          end
          3'd5: begin
            x_off = '0;              y_off = style_i.stroke;
            rect.w = style_i.stroke; rect.h = style_i.arm;
          end
          default: begin
            x_off = style_i.stroke;  y_off = style_i.y_mid;
            rect.w = style_i.bar;    rect.h = style_i.stroke;
          end
        endcase
        rect.x     = cur_q.x + x_off;
        rect.y     = cur_q.y + y_off;
        rect.color = cur_q.lit[step_q] ? cur_q.lit_color : cur_q.dark_color;
        rect.last  = (step_q == DigitLastStep);
      end
      default: begin
        // Rejected request: one all-zero rectangle flagged invalid.
        rect.status = 1'b1;
        rect.last   = 1'b1;
      end
    endcase
    rect.x = rect.x & CoordMask;
    rect.y = rect.y & CoordMask;
    rect.w = rect.w & CoordMask;
    rect.h = rect.h & CoordMask;
  end

  assign load  = cur_v_q && (!out_v_q || out_ready_i);
  assign pop_o = head_valid_i && (!cur_v_q || (load && rect.last));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_v_q <= 1'b0;
      step_q  <= '0;
      out_v_q <= 1'b0;
    end else begin
      if (pop_o) begin
        cur_v_q <= 1'b1;
        step_q  <= '0;
      end else if (load) begin
        if (rect.last) begin
          cur_v_q <= 1'b0;
        end
        step_q <= step_q + 1'b1;
      end
      if (load) begin
        out_v_q <= 1'b1;
      end else if (out_ready_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_q <= head_i;
    end
    if (load) begin
      out_q <= rect;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_o       = out_q;

endmodule

// ----- rtl/seven_segment_rect_generator.sv -----
// Top level of the seven-segment rectangle generator.
`timescale 1ns / 1ps

// Turns requests to draw a seven-segment digit cell or a colon into fill rectangles.
// The slave stream takes one request per transfer; the master stream gives its
// rectangles in order, tlast marking the final one and tuser flagging an invalid
// style or glyph code (then a single all-zero rectangle is given).
// A digit gives seven rectangles (segments a to g), a colon two, an error one.
// The back end puts out one rectangle per cycle from its output register, as long
// as the receiver keeps tready high; with the next request already queued, requests
// follow each other back to back.
// A request passes the input register, the queue and the back end's current-request
// register before its first rectangle is held in the output register.
// The front end keeps accepting while the back end works, up to the queue depth
// plus its input register; when the receiver stalls, the current rectangle is
// held and the back end, then the queue and finally s_axis_tready back up.
// The user must write configuration only while no request is in flight; the block itself
// leaves this to the user. A write applies to requests transferred at any later edge.
// Reset empties the pipeline and loads stroke 4, width 24 and height 40.
module seven_segment_rect_generator #(
  parameter int unsigned COORD_WIDTH = ssrg_pkg::COORD_WIDTH_DEFAULT
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Configuration write port.
  input  logic                              cfg_we_i,
  input  logic [ssrg_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [15:0]                       cfg_data_i,
  // Request stream.
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // From bit 0: origin_x[16], origin_y[16], glyph_code[4], lit colour[16],
  // unlit colour[16], zero padding[4].
  input  logic [ssrg_pkg::S_TDATA_W-1:0]    s_axis_tdata,
  // kind: 0 digit cell, 1 colon.
  input  logic                              s_axis_tuser,
  // Rectangle stream.
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // From bit 0: rect_x[16], rect_y[16], rect_width[16], rect_height[16], fill_color[16].
  output logic [ssrg_pkg::M_TDATA_W-1:0]    m_axis_tdata,
  // status: 0 valid rectangle, 1 invalid style or glyph code.
  output logic                              m_axis_tuser,
  output logic                              m_axis_tlast
);
  import ssrg_pkg::*;

  req_t    req;
  entry_t  entry, head;
  style_t  style;
  result_t result;
  logic    push, full, pop, head_valid;

  // Unpack the request; the padding bits are ignored.
  assign req = {s_axis_tuser, s_axis_tdata[15:0], s_axis_tdata[31:16],
                s_axis_tdata[35:32], s_axis_tdata[51:36], s_axis_tdata[67:52]};

  ssrg_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .req_i      (req),
    .push_o     (push),
    .entry_o    (entry),
    .full_i     (full),
    .style_o    (style)
  );

  ssrg_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (entry),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (head_valid),
    .head_o  (head)
  );

  ssrg_back #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .style_i      (style),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_o        (result)
  );

  assign m_axis_tdata = {result.color, result.h, result.w, result.y, result.x};
  assign m_axis_tuser = result.status;
  assign m_axis_tlast = result.last;

endmodule

// ----- rtl/ssrg_checker.sv -----
// Port-level checks of the seven-segment rectangle generator, bound to the top level.
`timescale 1ns / 1ps

module ssrg_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [ssrg_pkg::M_TDATA_W-1:0] m_axis_tdata,
  input logic                           m_axis_tuser,
  input logic                           m_axis_tlast
);

  // A stalled rectangle stays offered.
  a_valid_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("rectangle withdrawn while stalled");

  // A stalled rectangle keeps its contents.
  a_payload_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("rectangle changed while stalled");

  // A rejected request ends with its single error result.
  a_error_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
    else $error("error result not marked last");

  // An error result carries an empty rectangle.
  a_error_is_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> (m_axis_tdata == '0))
    else $error("error result carries rectangle data");

endmodule

bind seven_segment_rect_generator ssrg_checker u_ssrg_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
